FILE: sv/ddpmm_pkg.sv
// ----------------------------------------------------------------------------
// ddpmm_pkg
// Shared types and constants of the dot-product engine for G = A * B^T.
// ----------------------------------------------------------------------------
package ddpmm_pkg;

   // Store geometry.
   localparam int MAX_ROWS = 64;
   localparam int MAX_LEN  = 64;
   localparam int DEPTH    = MAX_ROWS * MAX_LEN;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int LEN_W    = $clog2(MAX_LEN + 1);

   // Payload widths.
   localparam int MODE_W  = 2;
   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int VALUE_W = 16;
   localparam int SUM_W   = 38;
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int ACC_W   = PROD_W + LEN_W;
   localparam int EXT_W   = (ACC_W > SUM_W) ? ACC_W : SUM_W;

   // Configuration port.
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam logic [CFG_W-1:0]     CFG_RESET  = 7'd64;
   localparam logic [CSR_IDX_W-1:0] CSR_M_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_N_LEN  = 2'd2;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   // Queue between front and back.
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      KIND_LOAD_A,
      KIND_LOAD_B,
      KIND_QUERY
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [ROW_W-1:0]           row;
      logic [COL_W-1:0]           col;
      logic signed [VALUE_W-1:0]  value;
      logic                       bad;
      logic [LEN_W-1:0]           len;
   } qentry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

endpackage

FILE: sv/ddpmm_ram.sv
// ----------------------------------------------------------------------------
// ddpmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ddpmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ddpmm_front.sv
// ----------------------------------------------------------------------------
// ddpmm_front
// Accepts request beats, holds the configuration registers, classifies each
// request and places each query and each in-range load in a short queue for the back end.
// ----------------------------------------------------------------------------
module ddpmm_front import ddpmm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [ROW_W-1:0]           req_row,
   input  logic [COL_W-1:0]           req_col,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       q_vld,
   output qentry_type                 q_head,
   input  logic                       q_pop
);

   logic [CFG_W-1:0]  m_rows_ff, k_rows_ff, n_len_ff;
   qentry_type        q_mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic       accept;
   logic       push;
   logic       load_ok;
   qentry_type entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_rows_ff <= CFG_RESET;
         k_rows_ff <= CFG_RESET;
         n_len_ff  <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_M_ROWS: m_rows_ff <= csr_wdata;
            CSR_K_ROWS: k_rows_ff <= csr_wdata;
            CSR_N_LEN:  n_len_ff  <= csr_wdata;
            default:    ;
         endcase
      end
   end

   assign req_stall = (count_ff == QCNT_W'(QDEPTH));
   assign accept    = req_valid && !req_stall;
   assign load_ok   = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_LEN);

   always_comb begin
      entry.row   = req_row;
      entry.col   = req_col;
      entry.value = req_value;
      entry.bad   = ({1'b0, req_row} >= m_rows_ff) || (32'(req_row) >= MAX_ROWS) ||
                    ({1'b0, req_col} >= k_rows_ff) || (32'(req_col) >= MAX_ROWS);
      entry.len   = (32'(n_len_ff) > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(n_len_ff);
      entry.kind  = KIND_QUERY;
      push        = 1'b0;
      unique case (req_mode)
         MODE_LOAD_A: begin
            entry.kind = KIND_LOAD_A;
            push       = accept && load_ok;
         end
         MODE_LOAD_B: begin
            entry.kind = KIND_LOAD_B;
            push       = accept && load_ok;
         end
         MODE_QUERY: begin
            entry.kind = KIND_QUERY;
            push       = accept;
         end
         default: begin
            // The unused mode is taken and dropped.
            push = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= entry;
      end
   end

   assign q_vld  = (count_ff != '0);
   assign q_head = q_mem_ff[rd_ptr_ff];

endmodule

FILE: sv/ddpmm_back.sv
// ----------------------------------------------------------------------------
// ddpmm_back
// Carries out queued requests: writes loads into the A and B stores and runs
// queries through one multiply-accumulate, one column per cycle.
// ----------------------------------------------------------------------------
module ddpmm_back import ddpmm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_vld,
   input  qentry_type                 q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ROW_W-1:0]           rsp_out_row,
   output logic [COL_W-1:0]           rsp_out_col,
   output logic signed [SUM_W-1:0]    rsp_sum,
   output logic                       rsp_bad_index
);

   localparam logic signed [EXT_W-1:0] SUM_MAX_E = (EXT_W'(1) <<< (SUM_W - 1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] SUM_MIN_E = -SUM_MAX_E - EXT_W'(1);

   state_type state_ff, state_in;

   logic [ROW_W-1:0]          arow_ff;
   logic [COL_W-1:0]          bcol_ff;
   logic [LEN_W-1:0]          len_ff, cnt_ff;
   logic [ADDR_W-1:0]         a_base_ff, b_base_ff;
   logic                      rd_vld_ff, prod_vld_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   logic                      rsp_valid_ff;
   logic [ROW_W-1:0]          rsp_row_ff;
   logic [COL_W-1:0]          rsp_col_ff;
   logic signed [SUM_W-1:0]   rsp_sum_ff;
   logic                      rsp_bad_ff;

   logic slot_free, pipe_empty, quick;
   logic wr_a, wr_b, start_run, issue, emit_zero, emit_acc;

   logic [ADDR_W-1:0]         wr_addr, a_rd_addr, b_rd_addr;
   logic signed [VALUE_W-1:0] a_rd_data, b_rd_data;
   logic signed [EXT_W-1:0]   acc_ext, acc_sat;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign pipe_empty = !rd_vld_ff && !prod_vld_ff;
   // A bad index or an empty row needs no pass over the stores.
   assign quick      = q_head.bad || (q_head.len == '0);

   assign wr_addr   = ADDR_W'(q_head.row) * ADDR_W'(MAX_LEN) + ADDR_W'(q_head.col);
   assign a_rd_addr = a_base_ff + ADDR_W'(cnt_ff);
   assign b_rd_addr = b_base_ff + ADDR_W'(cnt_ff);

   ddpmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_a_store (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (q_head.value),
      .rd_en   (issue),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   ddpmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_b_store (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (q_head.value),
      .rd_en   (issue),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_vld && (q_head.kind == KIND_QUERY) && !quick) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if ((cnt_ff + 1'b1) == len_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty && slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop     = 1'b0;
      wr_a      = 1'b0;
      wr_b      = 1'b0;
      start_run = 1'b0;
      issue     = 1'b0;
      emit_zero = 1'b0;
      emit_acc  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_vld) begin
               unique case (q_head.kind)
                  KIND_LOAD_A: begin
                     q_pop = 1'b1;
                     wr_a  = 1'b1;
                  end
                  KIND_LOAD_B: begin
                     q_pop = 1'b1;
                     wr_b  = 1'b1;
                  end
                  KIND_QUERY: begin
                     if (quick) begin
                        q_pop     = slot_free;
                        emit_zero = slot_free;
                     end else begin
                        q_pop     = 1'b1;
                        start_run = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN:   issue    = 1'b1;
         ST_DRAIN: emit_acc = pipe_empty && slot_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start_run) begin
         arow_ff   <= q_head.row;
         bcol_ff   <= q_head.col;
         len_ff    <= q_head.len;
         a_base_ff <= ADDR_W'(q_head.row) * ADDR_W'(MAX_LEN);
         b_base_ff <= ADDR_W'(q_head.col) * ADDR_W'(MAX_LEN);
         cnt_ff    <= '0;
         acc_ff    <= '0;
      end else begin
         if (issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (prod_vld_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
      if (rd_vld_ff) begin
         prod_ff <= a_rd_data * b_rd_data;
      end
   end

   assign acc_ext = EXT_W'(acc_ff);

   always_comb begin
      acc_sat = acc_ext;
      if (acc_ext > SUM_MAX_E) begin
         acc_sat = SUM_MAX_E;
      end else if (acc_ext < SUM_MIN_E) begin
         acc_sat = SUM_MIN_E;
      end
   end

   // Result register; it holds a beat while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_zero || emit_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_zero) begin
         rsp_row_ff <= q_head.row;
         rsp_col_ff <= q_head.col;
         rsp_sum_ff <= '0;
         rsp_bad_ff <= q_head.bad;
      end else if (emit_acc) begin
         rsp_row_ff <= arow_ff;
         rsp_col_ff <= bcol_ff;
         rsp_sum_ff <= SUM_W'(acc_sat);
         rsp_bad_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_sum       = rsp_sum_ff;
   assign rsp_bad_index = rsp_bad_ff;

endmodule

FILE: sv/dense_dot_product_matmul_top.sv
// ----------------------------------------------------------------------------
// dense_dot_product_matmul_top
// Returns one element of G = A * B^T per query from on-chip A and B stores.
//
//   Channel  Ports                                  Beat moves
//   req      req_valid / req_stall, req_* fields    load A, load B or query
//   rsp      rsp_valid / rsp_stall, rsp_* fields    one element per query
//   csr      csr_wr_en, csr_index, csr_wdata        m_rows, k_rows, n_len
//
// A load beat is popped and written to its store in the same cycle.
// A query holds the back end while the single multiply-accumulate walks n_len
// column pairs, with n_len capped at MAX_LEN, one pair per cycle behind the
// registered store reads.
// A query with a bad index or n_len of zero skips the stores and answers with a zero sum.
// Reset is synchronous; the stores are not cleared.
// A two-beat queue lets requests arrive while the back end is busy or a
// result waits on rsp_stall.
// ----------------------------------------------------------------------------
module dense_dot_product_matmul_top import ddpmm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [ROW_W-1:0]           req_row,
   input  logic [COL_W-1:0]           req_col,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ROW_W-1:0]           rsp_out_row,
   output logic [COL_W-1:0]           rsp_out_col,
   output logic signed [SUM_W-1:0]    rsp_sum,
   output logic                       rsp_bad_index
);

   logic       q_vld;
   logic       q_pop;
   qentry_type q_head;

   ddpmm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_value (req_value),
      .q_vld     (q_vld),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   ddpmm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_vld         (q_vld),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_sum       (rsp_sum),
      .rsp_bad_index (rsp_bad_index)
   );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the A * B^T dot-product engine. A queue of load and
// query beats feeds a clocked driver; a clocked monitor checks every returned
// element against a bench-side model of the two stores and the registers.
// ----------------------------------------------------------------------------
module tb_top;
   import ddpmm_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int MAX_GAP     = 14;
   localparam int LONG_HOLD   = 400;
   localparam int HOLD_STEP   = 300;
   localparam int PAUSE_LEN   = MAX_LEN + 36;
   localparam int PHASE_BEATS = 250;
   localparam int NUM_PHASES  = 8;

   typedef struct {
      logic [MODE_W-1:0]         mode;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
   } req_beat_type;

   typedef struct {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [SUM_W-1:0] sum;
      logic                    bad;
   } element_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CFG_W-1:0]          csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode = '0;
   logic [ROW_W-1:0]          req_row = '0;
   logic [COL_W-1:0]          req_col = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [ROW_W-1:0]          rsp_out_row;
   logic [COL_W-1:0]          rsp_out_col;
   logic signed [SUM_W-1:0]   rsp_sum;
   logic                      rsp_bad_index;

   dense_dot_product_matmul_top DUT (.*);

   always #4 clock = ~clock;

   // Bench copy of the registers and the stores.
   int cfg_m = 64;
   int cfg_k = 64;
   int cfg_n = 64;
   logic signed [VALUE_W-1:0] a_mem [MAX_ROWS][MAX_LEN];
   logic signed [VALUE_W-1:0] b_mem [MAX_ROWS][MAX_LEN];

   // Which store entries the stimulus has written so far.
   logic [MAX_LEN-1:0] a_filled [MAX_ROWS];
   logic [MAX_LEN-1:0] b_filled [MAX_ROWS];

   req_beat_type requests_to_send [$];
   element_type  owed_elements [$];

   bit sender_quiet = 1'b0;
   bit receiver_quiet = 1'b0;
   int hold_left = 0;
   int hold_next = 120;
   int stim_count = 0;
   int error_count = 0;
   int loads_seen = 0;
   int queries_seen = 0;
   int bad_seen = 0;
   int ignored_seen = 0;
   int phases_run = 0;

   function automatic int eff_len();
      return (cfg_n > MAX_LEN) ? MAX_LEN : cfg_n;
   endfunction

   function automatic logic signed [SUM_W-1:0] dot_of_rows(int ar, int br, int len);
      longint acc;
      longint hi;
      acc = 0;
      hi = (64'sd1 <<< (SUM_W - 1)) - 1;
      for (int j = 0; j < len; j++)
         acc += longint'(a_mem[ar][j]) * longint'(b_mem[br][j]);
      if (acc > hi)
         acc = hi;
      if (acc < -hi - 1)
         acc = -hi - 1;
      return acc[SUM_W-1:0];
   endfunction

   task automatic apply_beat(req_beat_type b);
      element_type e;
      case (b.mode)
         MODE_LOAD_A: begin
            a_mem[b.row][b.col] = b.value;
            loads_seen++;
         end
         MODE_LOAD_B: begin
            b_mem[b.row][b.col] = b.value;
            loads_seen++;
         end
         MODE_QUERY: begin
            e.row = b.row;
            e.col = b.col;
            e.bad = (int'(b.row) >= cfg_m) || (int'(b.col) >= cfg_k);
            e.sum = e.bad ? '0 : dot_of_rows(b.row, b.col, eff_len());
            owed_elements.push_back(e);
            queries_seen++;
            if (e.bad)
               bad_seen++;
         end
         default: ignored_seen++;
      endcase
   endtask

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= 10)
         $display("%s", msg);
   endtask

   // Driver: one beat at a time, with a random gap after each unless the sender is quiet.
   int gap_left = 0;
   always @(posedge clock) begin
      req_beat_type nb;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            apply_beat('{req_mode, req_row, req_col, req_value});
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (requests_to_send.size() != 0) begin
               nb = requests_to_send.pop_front();
               req_mode  <= nb.mode;
               req_row   <= nb.row;
               req_col   <= nb.col;
               req_value <= nb.value;
               req_valid <= 1'b1;
               gap_left = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long output hold-off, so the engine fills up and pushes back on requests.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (queries_seen >= hold_next) begin
         hold_left <= LONG_HOLD;
         hold_next <= hold_next + HOLD_STEP;
      end
   end

   // Monitor: checks each accepted element against the oldest one owed.
   int rsp_wait = 0;
   always @(posedge clock) begin
      element_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_elements.size() == 0) begin
               note_failure($sformatf("Unexpected element row %0d col %0d sum %0d bad %0b",
                  rsp_out_row, rsp_out_col, rsp_sum, rsp_bad_index));
            end else begin
               e = owed_elements.pop_front();
               if (rsp_out_row !== e.row || rsp_out_col !== e.col ||
                   rsp_sum !== e.sum || rsp_bad_index !== e.bad)
                  note_failure($sformatf(
                     "Mismatch: expected row %0d col %0d sum %0d bad %0b, got %0d %0d %0d %0b",
                     e.row, e.col, e.sum, e.bad,
                     rsp_out_row, rsp_out_col, rsp_sum, rsp_bad_index));
            end
            rsp_wait = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end else if (rsp_valid && rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_stall <= (rsp_wait != 0) || (hold_left != 0);
      end
   end

   function automatic bit row_ready(logic [MAX_LEN-1:0] filled, int len);
      logic [MAX_LEN-1:0] need;
      need = (len >= MAX_LEN) ? '1 : ((64'd1 << len) - 64'd1);
      return (filled & need) == need;
   endfunction

   function automatic int pick_ready(bit from_b);
      int start;
      int r;
      start = $urandom_range(0, MAX_ROWS - 1);
      for (int i = 0; i < MAX_ROWS; i++) begin
         r = (start + i) % MAX_ROWS;
         if (row_ready(from_b ? b_filled[r] : a_filled[r], eff_len()))
            return r;
      end
      return -1;
   endfunction

   function automatic int pick_row(int limit);
      if (limit > 0 && $urandom_range(0, 3) != 0)
         return $urandom_range(0, ((limit > MAX_ROWS) ? MAX_ROWS : limit) - 1);
      return $urandom_range(0, MAX_ROWS - 1);
   endfunction

   task automatic push_beat(logic [MODE_W-1:0] mode, int row, int col,
                            logic signed [VALUE_W-1:0] value);
      requests_to_send.push_back('{mode, row[ROW_W-1:0], col[COL_W-1:0], value});
      if (mode != MODE_UNUSED)
         stim_count++;
      if (mode == MODE_LOAD_A)
         a_filled[row][col] = 1'b1;
      else if (mode == MODE_LOAD_B)
         b_filled[row][col] = 1'b1;
   endtask

   // Loads columns 0 .. count-1 of one row, in rotated order.
   task automatic fill_row(bit from_b, int r, int count);
      int start;
      bit extreme;
      logic signed [VALUE_W-1:0] ext_v;
      logic signed [VALUE_W-1:0] v;
      start = $urandom_range(0, MAX_LEN - 1);
      extreme = ($urandom_range(0, 7) == 0);
      ext_v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      for (int j = 0; j < count; j++) begin
         v = extreme ? ext_v : VALUE_W'($urandom);
         push_beat(from_b ? MODE_LOAD_B : MODE_LOAD_A, r, (start + j) % count, v);
      end
   endtask

   // A query goes out only if it never touches an entry that was not loaded.
   task automatic try_query(int r, int c);
      bit bad;
      if (r < 0 || c < 0)
         return;
      bad = (r >= cfg_m) || (c >= cfg_k);
      if (bad || eff_len() == 0 ||
          (row_ready(a_filled[r], eff_len()) && row_ready(b_filled[c], eff_len())))
         push_beat(MODE_QUERY, r, c, VALUE_W'($urandom));
   endtask

   task automatic random_step();
      int choice;
      int r;
      int c;
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
         r = pick_row(cfg_m);
         c = pick_row(cfg_k);
         if (!row_ready(a_filled[r], eff_len()) || $urandom_range(0, 3) == 0)
            fill_row(1'b0, r, eff_len());
         if (!row_ready(b_filled[c], eff_len()) || $urandom_range(0, 3) == 0)
            fill_row(1'b1, c, eff_len());
         try_query(r, c);
         repeat ($urandom_range(0, 3))
            try_query(pick_ready(1'b0), pick_ready(1'b1));
      end else if (choice < 75) begin
         if ($urandom_range(0, 2) == 0)
            try_query($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_ROWS - 1));
         else
            try_query(pick_ready(1'b0), pick_ready(1'b1));
      end else if (choice < 90) begin
         push_beat($urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A,
            $urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_LEN - 1),
            VALUE_W'($urandom));
      end else if (choice < 95) begin
         push_beat(MODE_UNUSED, $urandom_range(0, MAX_ROWS - 1),
            $urandom_range(0, MAX_LEN - 1), VALUE_W'($urandom));
      end else begin
         // Broken sequence: a row loaded possibly only part way, then a query tried at that row index.
         r = $urandom_range(0, MAX_ROWS - 1);
         fill_row(1'($urandom_range(0, 1)), r, $urandom_range(0, eff_len()));
         try_query(r, $urandom_range(0, MAX_ROWS - 1));
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CFG_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_M_ROWS: cfg_m = val;
         CSR_K_ROWS: cfg_k = val;
         CSR_N_LEN:  cfg_n = val;
         default: ;
      endcase
   endtask

   task automatic set_regs(int m, int k, int n);
      csr_write(CSR_M_ROWS, m);
      csr_write(CSR_K_ROWS, k);
      csr_write(CSR_N_LEN, n);
      phases_run++;
   endtask

   // Waits until every beat is in and every element is back, then lets a
   // trailing load or two retire before anything else happens.
   task automatic drain_and_pause();
      do
         @(negedge clock);
      while (requests_to_send.size() != 0 || req_valid || owed_elements.size() != 0);
      repeat (PAUSE_LEN) @(posedge clock);
   endtask

   initial begin
      automatic int ph_m [NUM_PHASES] = '{64, 0, 64, 40, 127, 64, 17, 64};
      automatic int ph_k [NUM_PHASES] = '{64, 64, 0, 23, 127, 64, 50, 64};
      automatic int ph_n [NUM_PHASES] = '{8, 8, 5, 0, 127, 64, 3, 1};
      for (int i = 0; i < MAX_ROWS; i++) begin
         a_filled[i] = '0;
         b_filled[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme values, full-scale products and an unused mode.
      set_regs(64, 64, 4);
      for (int j = 0; j < 4; j++) begin
         push_beat(MODE_LOAD_A, 0, j, (j == 1 || j == 2) ? 16'sh8000 : 16'sh7FFF);
         push_beat(MODE_LOAD_B, 63, j, (j < 2) ? 16'sh7FFF : 16'sh8000);
         push_beat(MODE_LOAD_A, 63, j, 16'sh8000);
         push_beat(MODE_LOAD_B, 0, j, 16'sh8000);
      end
      push_beat(MODE_LOAD_B, 31, 63, 16'sh5555);
      push_beat(MODE_QUERY, 0, 63, 16'sh7FFF);
      push_beat(MODE_QUERY, 63, 0, 16'sh0000);
      push_beat(MODE_UNUSED, 63, 63, 16'shFFFF);
      push_beat(MODE_QUERY, 63, 63, 16'shFFFF);
      push_beat(MODE_QUERY, 0, 0, 16'sh8000);
      drain_and_pause();

      // Directed: out-of-range rows on either side, and a zero row length.
      set_regs(63, 63, 0);
      push_beat(MODE_QUERY, 63, 0, 16'sh0000);
      push_beat(MODE_QUERY, 0, 63, 16'sh0000);
      push_beat(MODE_QUERY, 0, 0, 16'sh0000);
      drain_and_pause();

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_regs(ph_m[p], ph_k[p], ph_n[p]);
         sender_quiet = (p % 3 == 1);
         receiver_quiet = (p % 4 == 2);
         stim_count = 0;
         while (stim_count < PHASE_BEATS)
            random_step();
         drain_and_pause();
      end

      $display("Run covered %0d load beats, %0d queries (%0d with a bad index), %0d ignored",
         loads_seen, queries_seen, bad_seen, ignored_seen);
      $display("beats over %0d register settings, with random gaps and long output hold-offs.",
         phases_run);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timeout: the run did not drain in time.");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: sim.f
sv/ddpmm_pkg.sv
sv/ddpmm_ram.sv
sv/ddpmm_front.sv
sv/ddpmm_back.sv
sv/dense_dot_product_matmul_top.sv
tb/sv/tb_top.sv
